FILE: design/cje_pkg.sv
// shared types, codes and the operation program of the cubic julia engine
package cje_pkg;

  // operand and destination codes of the datapath
  typedef logic [3:0] opnd_t;
  localparam opnd_t OPD_ZR  = 4'd0;
  localparam opnd_t OPD_ZI  = 4'd1;
  localparam opnd_t OPD_AR  = 4'd2;
  localparam opnd_t OPD_AI  = 4'd3;
  localparam opnd_t OPD_BR  = 4'd4;
  localparam opnd_t OPD_BI  = 4'd5;
  localparam opnd_t OPD_RR  = 4'd6;
  localparam opnd_t OPD_RI  = 4'd7;
  localparam opnd_t OPD_ONE = 4'd8;
  localparam opnd_t OPD_T0  = 4'd9;
  localparam opnd_t OPD_T1  = 4'd10;
  localparam opnd_t OPD_T2  = 4'd11;
  localparam opnd_t OPD_T3  = 4'd12;
  localparam opnd_t OPD_T4  = 4'd13;
  localparam opnd_t OPD_T5  = 4'd14;

  // operation kinds
  typedef logic [1:0] opk_t;
  localparam opk_t OPK_MUL = 2'd0;
  localparam opk_t OPK_ADD = 2'd1;
  localparam opk_t OPK_SUB = 2'd2;

  typedef struct packed {
    opk_t  kind;
    opnd_t dst;
    opnd_t src_a;
    opnd_t src_b;
  } uop_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // program segments
  localparam pc_t BND_FIRST = 5'd0;
  localparam pc_t BND_LAST  = 5'd2;
  localparam pc_t MAP_FIRST = 5'd3;
  localparam pc_t MAP_LAST  = 5'd22;
  localparam pc_t RAY_FIRST = 5'd23;
  localparam pc_t RAY_LAST  = 5'd25;

  // configuration register indexes
  localparam logic [7:0] CFG_A_RE  = 8'd0;
  localparam logic [7:0] CFG_A_IM  = 8'd1;
  localparam logic [7:0] CFG_B_RE  = 8'd2;
  localparam logic [7:0] CFG_B_IM  = 8'd3;
  localparam logic [7:0] CFG_BOUND = 8'd4;
  localparam logic [7:0] CFG_R_RE  = 8'd5;
  localparam logic [7:0] CFG_R_IM  = 8'd6;
  localparam logic [7:0] CFG_LIMIT = 8'd7;

  // reset values in q.32 form, scaled to the fraction width at the top level
  localparam longint Q32_A_RE  = -64'sd6442450944;
  localparam longint Q32_A_IM  = -64'sd2147483648;
  localparam longint Q32_B_RE  = 64'sd2147483648;
  localparam longint Q32_B_IM  = 64'sd6442450944;
  localparam longint Q32_BOUND = 64'sd3955727586138;
  localparam longint Q32_R_RE  = 64'sd865085870;
  localparam longint Q32_R_IM  = -64'sd5330900523;
  localparam logic [15:0] RST_LIMIT = 16'd100;

  // color encoding
  localparam int COLOR_STEP = 4;
  localparam logic [19:0] COLOR_RAY_OFS = 20'd11;
  localparam logic [19:0] COLOR_INSIDE  = 20'hFFFFF;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic start;
    uop_t uop;
  } dp_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic done;
    logic sat;
    logic t0_neg;
    logic t0_ge;
  } dp_sts_t;

  // finished item summary from the controller
  typedef struct packed {
    logic        fin;
    logic        in_set;
    logic        map_mode;
    logic [15:0] iter;
  } ctl_res_t;

  function automatic logic [63:0] scale_q32(longint v, int frac);
    logic [63:0] r;
    if (frac >= 32) begin
      r = 64'(v <<< (frac - 32));
    end else begin
      r = 64'(v >>> (32 - frac));
    end
    return r;
  endfunction

  function automatic uop_t mk(opk_t k, opnd_t d, opnd_t a, opnd_t b);
    uop_t u;
    u.kind = k;
    u.dst = d;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  // operation program: bound test, one map step, ray side
  function automatic uop_t prog_rom(pc_t pc);
    uop_t u;
    unique case (pc)
      5'd0:    u = mk(OPK_MUL, OPD_T0, OPD_ZR, OPD_ZR);
      5'd1:    u = mk(OPK_MUL, OPD_T1, OPD_ZI, OPD_ZI);
      5'd2:    u = mk(OPK_ADD, OPD_T0, OPD_T0, OPD_T1);
      5'd3:    u = mk(OPK_MUL, OPD_T0, OPD_ZR, OPD_ZR);
      5'd4:    u = mk(OPK_MUL, OPD_T1, OPD_ZI, OPD_ZI);
      5'd5:    u = mk(OPK_SUB, OPD_T2, OPD_T0, OPD_T1);
      5'd6:    u = mk(OPK_MUL, OPD_T0, OPD_ZR, OPD_ZI);
      5'd7:    u = mk(OPK_ADD, OPD_T3, OPD_T0, OPD_T0);
      5'd8:    u = mk(OPK_MUL, OPD_T0, OPD_AR, OPD_ZR);
      5'd9:    u = mk(OPK_MUL, OPD_T1, OPD_AI, OPD_ZI);
      5'd10:   u = mk(OPK_SUB, OPD_T0, OPD_T0, OPD_T1);
      5'd11:   u = mk(OPK_ADD, OPD_T4, OPD_T0, OPD_BR);
      5'd12:   u = mk(OPK_MUL, OPD_T0, OPD_AI, OPD_ZR);
      5'd13:   u = mk(OPK_MUL, OPD_T1, OPD_AR, OPD_ZI);
      5'd14:   u = mk(OPK_ADD, OPD_T0, OPD_T0, OPD_T1);
      5'd15:   u = mk(OPK_ADD, OPD_T5, OPD_T0, OPD_BI);
      5'd16:   u = mk(OPK_MUL, OPD_T0, OPD_T2, OPD_T4);
      5'd17:   u = mk(OPK_MUL, OPD_T1, OPD_T3, OPD_T5);
      5'd18:   u = mk(OPK_SUB, OPD_T0, OPD_T0, OPD_T1);
      5'd19:   u = mk(OPK_ADD, OPD_ZR, OPD_T0, OPD_ONE);
      5'd20:   u = mk(OPK_MUL, OPD_T0, OPD_T3, OPD_T4);
      5'd21:   u = mk(OPK_MUL, OPD_T1, OPD_T2, OPD_T5);
      5'd22:   u = mk(OPK_ADD, OPD_ZI, OPD_T0, OPD_T1);
      5'd23:   u = mk(OPK_MUL, OPD_T0, OPD_ZR, OPD_RI);
      5'd24:   u = mk(OPK_MUL, OPD_T1, OPD_ZI, OPD_RR);
      5'd25:   u = mk(OPK_ADD, OPD_T0, OPD_T0, OPD_T1);
      default: u = mk(OPK_ADD, OPD_T0, OPD_T0, OPD_T1);
    endcase
    return u;
  endfunction

endpackage

FILE: design/cje_ifs.sv
// valid/ready channel interfaces of the cubic julia engine

interface cje_in_if #(parameter int WORD_BITS = 48) ();
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic signed [WORD_BITS-1:0] z_re;
  logic signed [WORD_BITS-1:0] z_im;
  modport source (output valid, action, z_re, z_im, input ready);
  modport sink (input valid, action, z_re, z_im, output ready);
endinterface

interface cje_out_if #(parameter int WORD_BITS = 48) ();
  logic                        valid;
  logic                        ready;
  logic                        inside_res;
  logic [15:0]                 iterations;
  logic                        ray_side;
  logic signed [19:0]          color_index;
  logic signed [WORD_BITS-1:0] mapped_re;
  logic signed [WORD_BITS-1:0] mapped_im;
  modport source (output valid, inside_res, iterations, ray_side, color_index,
                  mapped_re, mapped_im, input ready);
  modport sink (input valid, inside_res, iterations, ray_side, color_index,
                mapped_re, mapped_im, output ready);
endinterface

interface cje_cfg_if #(parameter int WORD_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           index;
  logic [WORD_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/cje_datapath.sv
// fixed-point complex datapath: temporaries, saturating adder, sequential multiplier
module cje_datapath
  import cje_pkg::*;
#(
  parameter int FRAC_BITS = 32,
  parameter int WORD_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  input  logic signed [WORD_BITS-1:0] in_z_re,
  input  logic signed [WORD_BITS-1:0] in_z_im,
  input  logic signed [WORD_BITS-1:0] coef_a_re,
  input  logic signed [WORD_BITS-1:0] coef_a_im,
  input  logic signed [WORD_BITS-1:0] coef_b_re,
  input  logic signed [WORD_BITS-1:0] coef_b_im,
  input  logic signed [WORD_BITS-1:0] root_a_re,
  input  logic signed [WORD_BITS-1:0] root_a_im,
  input  logic [WORD_BITS-2:0]        escape_bound,
  output dp_sts_t                     sts,
  output logic signed [WORD_BITS-1:0] z_re,
  output logic signed [WORD_BITS-1:0] z_im
);

  localparam int W     = WORD_BITS;
  localparam int H     = (WORD_BITS + 1) / 2;
  localparam int PW    = 2 * H;
  localparam int ACC_W = 4 * H;
  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] zr_r, zi_r, t0_r, t1_r, t2_r, t3_r, t4_r, t5_r;
  logic                sat_r, sat_nxt;
  logic [W-1:0]        ma_r, mb_r;
  logic                neg_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [2:0]          step_r;
  logic                busy_r;
  logic                done_r;
  opnd_t               dst_r;

  logic signed [W-1:0] opa, opb;
  logic signed [W:0]   sum_ext;
  logic signed [W-1:0] add_res;
  logic                add_sat;
  logic [H-1:0]        xs, ys;
  logic [PW-1:0]       pp;
  logic [ACC_W-1:0]    pp_ext;
  logic [ACC_W-1:0]    q, qq;
  logic                rem;
  logic signed [W-1:0] mul_res;
  logic                mul_sat;
  logic                wr_en;
  opnd_t               wr_dst;
  logic signed [W-1:0] wr_val;

  // operand select
  function automatic logic signed [W-1:0] fetch(opnd_t c, logic signed [W-1:0] zr,
      logic signed [W-1:0] zi, logic signed [W-1:0] t0, logic signed [W-1:0] t1,
      logic signed [W-1:0] t2, logic signed [W-1:0] t3, logic signed [W-1:0] t4,
      logic signed [W-1:0] t5, logic signed [W-1:0] ar, logic signed [W-1:0] ai,
      logic signed [W-1:0] br, logic signed [W-1:0] bi, logic signed [W-1:0] rr,
      logic signed [W-1:0] ri);
    logic signed [W-1:0] v;
    unique case (c)
      OPD_ZR:  v = zr;
      OPD_ZI:  v = zi;
      OPD_AR:  v = ar;
      OPD_AI:  v = ai;
      OPD_BR:  v = br;
      OPD_BI:  v = bi;
      OPD_RR:  v = rr;
      OPD_RI:  v = ri;
      OPD_ONE: v = ONE;
      OPD_T0:  v = t0;
      OPD_T1:  v = t1;
      OPD_T2:  v = t2;
      OPD_T3:  v = t3;
      OPD_T4:  v = t4;
      OPD_T5:  v = t5;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = fetch(cmd.uop.src_a, zr_r, zi_r, t0_r, t1_r, t2_r, t3_r, t4_r, t5_r,
                coef_a_re, coef_a_im, coef_b_re, coef_b_im, root_a_re, root_a_im);
    opb = fetch(cmd.uop.src_b, zr_r, zi_r, t0_r, t1_r, t2_r, t3_r, t4_r, t5_r,
                coef_a_re, coef_a_im, coef_b_re, coef_b_im, root_a_re, root_a_im);
  end

  // saturating add and subtract
  always_comb begin
    if (cmd.uop.kind == OPK_SUB) begin
      sum_ext = {opa[W-1], opa} - {opb[W-1], opb};
    end else begin
      sum_ext = {opa[W-1], opa} + {opb[W-1], opb};
    end
    add_sat = sum_ext[W] ^ sum_ext[W-1];
    add_res = add_sat ? (sum_ext[W] ? VMIN : VMAX) : sum_ext[W-1:0];
  end

  // one half-word partial product per cycle
  always_comb begin
    xs = step_r[0] ? H'(ma_r >> H) : ma_r[H-1:0];
    ys = step_r[1] ? H'(mb_r >> H) : mb_r[H-1:0];
    pp = PW'(xs) * PW'(ys);
    pp_ext = ACC_W'(pp);
    unique case ({1'b0, step_r[0]} + {1'b0, step_r[1]})
      2'd0:    acc_nxt = acc_r + pp_ext;
      2'd1:    acc_nxt = acc_r + (pp_ext << H);
      default: acc_nxt = acc_r + (pp_ext << (2 * H));
    endcase
  end

  // scale back, round toward minus infinity, saturate
  always_comb begin
    q   = acc_r >> FRAC_BITS;
    rem = |acc_r[FRAC_BITS-1:0];
    qq  = q + ACC_W'(rem);
    if (neg_r) begin
      mul_sat = (|qq[ACC_W-1:W]) || (qq[W-1] && (|qq[W-2:0]));
      mul_res = mul_sat ? VMIN : (~q[W-1:0] + W'(!rem));
    end else begin
      mul_sat = |q[ACC_W-1:W-1];
      mul_res = mul_sat ? VMAX : q[W-1:0];
    end
  end

  // result write port
  always_comb begin
    wr_en   = 1'b0;
    wr_dst  = cmd.uop.dst;
    wr_val  = add_res;
    sat_nxt = sat_r;
    if (busy_r && step_r == 3'd4) begin
      wr_en  = 1'b1;
      wr_dst = dst_r;
      wr_val = mul_res;
      sat_nxt = sat_r | mul_sat;
    end else if (cmd.start && cmd.uop.kind != OPK_MUL) begin
      wr_en  = 1'b1;
      sat_nxt = sat_r | add_sat;
    end
  end

  // temporaries and point registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r <= in_z_re;
      zi_r <= in_z_im;
    end else if (wr_en) begin
      unique case (wr_dst)
        OPD_ZR:  zr_r <= wr_val;
        OPD_ZI:  zi_r <= wr_val;
        OPD_T0:  t0_r <= wr_val;
        OPD_T1:  t1_r <= wr_val;
        OPD_T2:  t2_r <= wr_val;
        OPD_T3:  t3_r <= wr_val;
        OPD_T4:  t4_r <= wr_val;
        OPD_T5:  t5_r <= wr_val;
        default: t0_r <= t0_r;
      endcase
    end
  end

  // multiplier operands and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start && cmd.uop.kind == OPK_MUL) begin
      ma_r  <= opa[W-1] ? (~opa + W'(1)) : opa;
      mb_r  <= opb[W-1] ? (~opb + W'(1)) : opb;
      neg_r <= opa[W-1] ^ opb[W-1];
      dst_r <= cmd.uop.dst;
      acc_r <= '0;
    end else if (busy_r && step_r != 3'd4) begin
      acc_r <= acc_nxt;
    end
  end

  // control of the multiplier and the sticky saturation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load) begin
        sat_r <= 1'b0;
      end else begin
        sat_r <= sat_nxt;
      end
      if (cmd.start && cmd.uop.kind == OPK_MUL) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (cmd.start) begin
        done_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  assign sts.done   = done_r;
  assign sts.sat    = sat_r;
  assign sts.t0_neg = t0_r[W-1];
  assign sts.t0_ge  = t0_r >= {1'b0, escape_bound};
  assign z_re = zr_r;
  assign z_im = zi_r;

endmodule

FILE: design/cje_ctrl.sv
// controller: item flow, iteration count and program sequencing
module cje_ctrl
  import cje_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        in_action,
  input  logic [15:0] limit,
  input  logic        out_free,
  input  dp_sts_t     sts,
  output logic        in_ready,
  output dp_cmd_t     cmd,
  output ctl_res_t    res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  pc_t         pc_r, pc_nxt;
  logic [15:0] iter_r, iter_nxt;
  logic        map_r, map_nxt;
  logic        inside_r, inside_nxt;

  // next state
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    iter_nxt     = iter_r;
    map_nxt      = map_r;
    inside_nxt   = inside_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.start    = 1'b0;
    cmd.uop      = prog_rom(pc_r);
    res.fin      = 1'b0;
    res.in_set   = inside_r;
    res.map_mode = map_r;
    res.iter     = iter_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          map_nxt    = in_action;
          iter_nxt   = '0;
          inside_nxt = 1'b0;
          if (in_action) begin
            pc_nxt    = MAP_FIRST;
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (iter_r >= limit) begin
          inside_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          pc_nxt    = BND_FIRST;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          priority if (pc_r == BND_LAST) begin
            pc_nxt    = (sts.sat || sts.t0_ge) ? RAY_FIRST : MAP_FIRST;
            state_nxt = S_ISSUE;
          end else if (pc_r == MAP_LAST) begin
            if (map_r) begin
              state_nxt = S_DONE;
            end else begin
              iter_nxt  = iter_r + 16'd1;
              state_nxt = S_CHECK;
            end
          end else if (pc_r == RAY_LAST) begin
            state_nxt = S_DONE;
          end else begin
            pc_nxt    = pc_r + 5'd1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        res.fin = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      iter_r   <= '0;
      map_r    <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      iter_r   <= iter_nxt;
      map_r    <= map_nxt;
      inside_r <= inside_nxt;
    end
  end

  // datapath completes only an operation that was issued
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == S_WAIT)
    else $error("datapath done outside wait");

  // every issue is followed by a wait for its result
  a_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_WAIT)
    else $error("issue not followed by wait");

  // a finished item is held until the output register takes it
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> state_r == S_DONE)
    else $error("finished item dropped");

  // items are only loaded while idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE && !cmd.start))
    else $error("load outside idle");

endmodule

FILE: design/cubic_julia_escape_time_ray.sv
// top level of the cubic julia escape-time engine with ray coloring
//
// Channels: in_ch takes an item (action, z_re, z_im); out_ch returns one
// result item per input item; cfg_ch writes the eight configuration
// registers by index (writes beyond index 7 are dropped), always ready.
// Action 0 iterates f(z) = z^2*(a*z+b)+1 until |z|^2 reaches the bound,
// a saturation occurs or the iteration limit is hit; action 1 returns f(z).
// One shared multiplier forms a product in steps (issue, four
// half-word partial products, result write, completion seen); an add or
// subtract writes its result as it is issued. One iteration is a limit
// check, a bound test and a map step; a map item runs a single map step.
// The multiplier products take most of the run time. One item is in work
// at a time; the next item is accepted while a finished result still
// waits in the output register.
// Reset (synchronous, active low) loads the default coefficients and
// clears the control; no item is pending afterwards.
// When the receiver stalls, the result stays in the output register and
// a second finished item waits in the controller until the register frees.
module cubic_julia_escape_time_ray
  import cje_pkg::*;
#(
  parameter int FRAC_BITS = 32,
  parameter int WORD_BITS = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  cje_in_if.sink     in_ch,
  cje_out_if.source  out_ch,
  cje_cfg_if.sink    cfg_ch
);

  localparam int W = WORD_BITS;
  localparam logic signed [W-1:0] RST_A_RE  = W'(scale_q32(Q32_A_RE, FRAC_BITS));
  localparam logic signed [W-1:0] RST_A_IM  = W'(scale_q32(Q32_A_IM, FRAC_BITS));
  localparam logic signed [W-1:0] RST_B_RE  = W'(scale_q32(Q32_B_RE, FRAC_BITS));
  localparam logic signed [W-1:0] RST_B_IM  = W'(scale_q32(Q32_B_IM, FRAC_BITS));
  localparam logic signed [W-1:0] RST_R_RE  = W'(scale_q32(Q32_R_RE, FRAC_BITS));
  localparam logic signed [W-1:0] RST_R_IM  = W'(scale_q32(Q32_R_IM, FRAC_BITS));
  localparam logic [W-2:0]        RST_BOUND = (W-1)'(scale_q32(Q32_BOUND, FRAC_BITS));

  logic signed [W-1:0] a_re_r, a_im_r, b_re_r, b_im_r, r_re_r, r_im_r;
  logic [W-2:0]        bound_r;
  logic [15:0]         limit_r;

  logic                out_valid_r;
  logic                inside_r, side_r;
  logic [15:0]         iter_r;
  logic signed [19:0]  color_r;
  logic signed [W-1:0] map_re_r, map_im_r;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  ctl_res_t            res;
  logic                in_ready;
  logic                out_free;
  logic signed [W-1:0] dp_z_re, dp_z_im;
  logic [19:0]         color_esc;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_re_r  <= RST_A_RE;
      a_im_r  <= RST_A_IM;
      b_re_r  <= RST_B_RE;
      b_im_r  <= RST_B_IM;
      bound_r <= RST_BOUND;
      r_re_r  <= RST_R_RE;
      r_im_r  <= RST_R_IM;
      limit_r <= RST_LIMIT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_A_RE:  a_re_r  <= cfg_ch.data;
        CFG_A_IM:  a_im_r  <= cfg_ch.data;
        CFG_B_RE:  b_re_r  <= cfg_ch.data;
        CFG_B_IM:  b_im_r  <= cfg_ch.data;
        CFG_BOUND: bound_r <= cfg_ch.data[W-2:0];
        CFG_R_RE:  r_re_r  <= cfg_ch.data;
        CFG_R_IM:  r_im_r  <= cfg_ch.data;
        CFG_LIMIT: limit_r <= cfg_ch.data[15:0];
        default:   limit_r <= limit_r;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  cje_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_ch.valid && in_ready),
    .in_action (in_ch.action),
    .limit     (limit_r),
    .out_free  (out_free),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .res       (res)
  );

  cje_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_z_re      (in_ch.z_re),
    .in_z_im      (in_ch.z_im),
    .coef_a_re    (a_re_r),
    .coef_a_im    (a_im_r),
    .coef_b_re    (b_re_r),
    .coef_b_im    (b_im_r),
    .root_a_re    (r_re_r),
    .root_a_im    (r_im_r),
    .escape_bound (bound_r),
    .sts          (sts),
    .z_re         (dp_z_re),
    .z_im         (dp_z_im)
  );

  // color of an escaped point
  assign color_esc = 20'(res.iter * COLOR_STEP) + (sts.t0_neg ? COLOR_RAY_OFS : 20'd0);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fin && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fin && out_free) begin
      priority if (res.map_mode) begin
        inside_r <= 1'b0;
        iter_r   <= '0;
        side_r   <= 1'b0;
        color_r  <= '0;
        map_re_r <= dp_z_re;
        map_im_r <= dp_z_im;
      end else if (res.in_set) begin
        inside_r <= 1'b1;
        iter_r   <= '0;
        side_r   <= 1'b0;
        color_r  <= COLOR_INSIDE;
        map_re_r <= '0;
        map_im_r <= '0;
      end else begin
        inside_r <= 1'b0;
        iter_r   <= res.iter;
        side_r   <= sts.t0_neg;
        color_r  <= color_esc;
        map_re_r <= '0;
        map_im_r <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.inside_res  = inside_r;
  assign out_ch.iterations  = iter_r;
  assign out_ch.ray_side    = side_r;
  assign out_ch.color_index = color_r;
  assign out_ch.mapped_re   = map_re_r;
  assign out_ch.mapped_im   = map_im_r;

endmodule
